// ===== hw/rtl/e2g_pkg.sv =====
package e2g_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int TURN_W         = 62;
    localparam int ACC_W          = 63;
    localparam int VEC_W          = 36;
    localparam int VEC_FRAC       = 30;
    localparam int CORDIC_STEPS   = 32;
    localparam int CFG_INDEX_W    = 2;

    localparam logic signed [VEC_W-1:0] GAIN_INV = VEC_W'(652032874);

    localparam logic [TURN_W-1:0] POLE_RA_RESET  = TURN_W'(64'd2300903221 << 30);
    localparam logic [TURN_W-1:0] POLE_DEC_RESET = TURN_W'(64'd323652629 << 30);
    localparam logic [TURN_W-1:0] NODE_LON_RESET = TURN_W'(64'd1466634933 << 30);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLE_RA  = 2'd0,
        CFG_POLE_DEC = 2'd1,
        CFG_NODE_LON = 2'd2
    } cfg_reg_t;

    // flag: output negate for rotation, half-turn offset for vectoring
    typedef struct packed {
        logic                    flag;
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } cordic_t;

    // elaboration-time helpers for the arctangent constants
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[63:0], n[k]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        p = udiv(64'd1 << 60, n);
        sum = '0;
        for (int k = 0; k < 40; k++)
        begin
            if (p != 64'd0)
            begin
                term = udiv(p, 64'(2 * k + 1));
                if ((k % 2) == 0)
                    sum = sum + term;
                else
                    sum = sum - term;
                p = udiv(p, n * n);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int sh;
        sum = '0;
        sh = i;
        for (int k = 0; k < 40; k++)
        begin
            if (sh <= 60)
            begin
                term = udiv((64'd1 << 60) >> sh, 64'(2 * k + 1));
                if ((k % 2) == 0)
                    sum = sum + term;
                else
                    sum = sum - term;
                sh = sh + 2 * i;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] to_turns(input logic [63:0] r, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = r;
        q = '0;
        for (int k = 0; k < TURN_W; k++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q = q | 64'd1;
            end
        end
        if ((rem << 1) >= d)
            q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [63:0] atan_entry(input int step);
        logic [63:0] pi;
        pi = 64'd16 * atan_recip(64'd5) - 64'd4 * atan_recip(64'd239);
        if (step == 0)
            return 64'd1 << (TURN_W - 3);
        return to_turns(atan_pow2(step), 64'd2 * pi);
    endfunction

endpackage

// ===== hw/rtl/e2g_if.sv =====
interface e2g_in_if import e2g_pkg::*; #(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();
    logic                         valid;
    logic                         ready;
    logic        [ANGLE_BITS-1:0] right_ascension;
    logic signed [ANGLE_BITS-1:0] declination;

    modport source (output valid, output right_ascension, output declination, input ready);
    modport sink (input valid, input right_ascension, input declination, output ready);
endinterface

interface e2g_out_if import e2g_pkg::*; #(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();
    logic                         valid;
    logic                         ready;
    logic        [ANGLE_BITS-1:0] galactic_longitude;
    logic signed [ANGLE_BITS-1:0] galactic_latitude;

    modport source (output valid, output galactic_longitude, output galactic_latitude,
                    input ready);
    modport sink (input valid, input galactic_longitude, input galactic_latitude,
                  output ready);
endinterface

// ===== hw/rtl/equatorial_to_galactic_top.sv =====
// equatorial to galactic conversion, fully pipelined
// sky_in (sink) takes one word per position: right ascension and declination as
// binary angles. gal_out (source) gives galactic longitude and latitude words.
// registers are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle; the block does not enforce it. index 0 pole right
// ascension, 1 pole declination, 2 node longitude, others ignored. the datapath is three
// 32-step cordic chains (sine/cosine, then two vectoring passes) plus seven stages for
// prefix, multiply and rounding. one word is accepted every cycle unless gal_out stalls.
// the pipeline advances as one unit: while gal_out holds a word that is not taken,
// every stage and sky_in.ready hold, so nothing is dropped or repeated.
// reset clears all valid bits and loads the J2000 pole and node values.
module equatorial_to_galactic_top import e2g_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ANGLE_BITS-1:0]  cfg_data,
    e2g_in_if.sink                 sky_in,
    e2g_out_if.source              gal_out
);

    localparam int SHIFT = TURN_W - ANGLE_BITS;
    localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(64'd1 << (TURN_W - 2));
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'd1 << (TURN_W - 1));
    localparam logic [TURN_W-1:0] ROUND_BIAS = TURN_W'(64'd1 << (SHIFT - 1));
    localparam logic signed [ANGLE_BITS-1:0] LAT_MAX =
        ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));

    function automatic cordic_t rot_prefix(input logic [TURN_W-1:0] a);
        cordic_t r;
        r.zero = 1'b0;
        r.flag = 1'b0;
        r.x    = GAIN_INV;
        r.y    = '0;
        r.z    = ACC_W'(signed'(a));
        if (r.z > QUARTER)
        begin
            r.z    = r.z - HALF;
            r.flag = 1'b1;
        end
        else if (r.z < -QUARTER)
        begin
            r.z    = r.z + HALF;
            r.flag = 1'b1;
        end
        return r;
    endfunction

    function automatic cordic_t vec_prefix(input logic signed [VEC_W-1:0] y,
                                           input logic signed [VEC_W-1:0] x);
        cordic_t r;
        r.zero = (x == '0) && (y == '0);
        r.flag = x[VEC_W-1];
        r.x    = x[VEC_W-1] ? -x : x;
        r.y    = x[VEC_W-1] ? -y : y;
        r.z    = '0;
        return r;
    endfunction

    function automatic logic [TURN_W-1:0] vec_angle(input cordic_t d);
        logic [ACC_W-1:0] s;
        s = (d.flag ? HALF : '0) + d.z;
        return d.zero ? '0 : s[TURN_W-1:0];
    endfunction

    function automatic logic signed [VEC_W-1:0] mulq(input logic signed [VEC_W-1:0] a,
                                                     input logic signed [VEC_W-1:0] b);
        logic signed [2*VEC_W-1:0] p;
        p = a * b;
        return VEC_W'(p >>> VEC_FRAC);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] round_out(input logic [TURN_W-1:0] a);
        logic [TURN_W-1:0] s;
        s = a + ROUND_BIAS;
        return s[TURN_W-1 -: ANGLE_BITS];
    endfunction

    // configuration, held at internal turn resolution
    logic [TURN_W-1:0] pole_ra_reg;
    logic [TURN_W-1:0] pole_dec_reg;
    logic [TURN_W-1:0] node_lon_reg;
    logic [TURN_W-1:0] cfg_wide;

    assign cfg_wide = TURN_W'({cfg_data}) << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_ra_reg  <= POLE_RA_RESET;
            pole_dec_reg <= POLE_DEC_RESET;
            node_lon_reg <= NODE_LON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_POLE_RA:  pole_ra_reg  <= cfg_wide;
                CFG_POLE_DEC: pole_dec_reg <= cfg_wide;
                CFG_NODE_LON: node_lon_reg <= cfg_wide;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en           = ~out_valid_reg | gal_out.ready;
    assign sky_in.ready = en;

    // prefix stage
    logic [TURN_W-1:0] ra_t;
    logic [TURN_W-1:0] dec_t;
    logic              p0_valid_reg;
    cordic_t           dec_p0_reg;
    cordic_t           dlt_p0_reg;
    cordic_t           pd_p0_reg;

    assign ra_t  = TURN_W'({sky_in.right_ascension}) << SHIFT;
    assign dec_t = TURN_W'({sky_in.declination}) << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else if (en)
            p0_valid_reg <= sky_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_p0_reg <= rot_prefix(dec_t);
            dlt_p0_reg <= rot_prefix(ra_t - pole_ra_reg);
            pd_p0_reg  <= rot_prefix(pole_dec_reg);
        end
    end

    // sine and cosine chains
    logic    sc_valid;
    cordic_t dec_sc;
    cordic_t dlt_sc;
    cordic_t pd_sc;

    e2g_cordic #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_dec (
        .clk (clk), .rst_n (rst_n), .en (en),
        .valid_i (p0_valid_reg), .d_i (dec_p0_reg), .side_i (1'b0),
        .valid_o (sc_valid), .d_o (dec_sc), .side_o ()
    );

    e2g_cordic #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_dlt (
        .clk (clk), .rst_n (rst_n), .en (en),
        .valid_i (p0_valid_reg), .d_i (dlt_p0_reg), .side_i (1'b0),
        .valid_o (), .d_o (dlt_sc), .side_o ()
    );

    e2g_cordic #(.VECTOR(1'b0), .SIDE_W(1)) u_sc_pd (
        .clk (clk), .rst_n (rst_n), .en (en),
        .valid_i (p0_valid_reg), .d_i (pd_p0_reg), .side_i (1'b0),
        .valid_o (), .d_o (pd_sc), .side_o ()
    );

    // first products
    logic signed [VEC_W-1:0] cd;
    logic signed [VEC_W-1:0] sd;
    logic signed [VEC_W-1:0] ca;
    logic signed [VEC_W-1:0] sa;
    logic signed [VEC_W-1:0] cp;
    logic signed [VEC_W-1:0] sp;

    assign cd = dec_sc.flag ? -dec_sc.x : dec_sc.x;
    assign sd = dec_sc.flag ? -dec_sc.y : dec_sc.y;
    assign ca = dlt_sc.flag ? -dlt_sc.x : dlt_sc.x;
    assign sa = dlt_sc.flag ? -dlt_sc.y : dlt_sc.y;
    assign cp = pd_sc.flag ? -pd_sc.x : pd_sc.x;
    assign sp = pd_sc.flag ? -pd_sc.y : pd_sc.y;

    logic                    m_valid_reg;
    logic signed [VEC_W-1:0] x_m_reg;
    logic signed [VEC_W-1:0] lsin_m_reg;
    logic signed [VEC_W-1:0] ssp_m_reg;
    logic signed [VEC_W-1:0] scp_m_reg;
    logic signed [VEC_W-1:0] cp_m_reg;
    logic signed [VEC_W-1:0] sp_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= sc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_m_reg    <= mulq(cd, ca);
            lsin_m_reg <= mulq(cd, sa);
            ssp_m_reg  <= mulq(sd, sp);
            scp_m_reg  <= mulq(sd, cp);
            cp_m_reg   <= cp;
            sp_m_reg   <= sp;
        end
    end

    // rotated vector
    logic                    n_valid_reg;
    logic signed [VEC_W-1:0] sinb_n_reg;
    logic signed [VEC_W-1:0] lcos_n_reg;
    logic signed [VEC_W-1:0] lsin_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sinb_n_reg <= ssp_m_reg + mulq(x_m_reg, cp_m_reg);
            lcos_n_reg <= scp_m_reg - mulq(x_m_reg, sp_m_reg);
            lsin_n_reg <= lsin_m_reg;
        end
    end

    // longitude vectoring, sin b rides along
    logic                    v1p_valid_reg;
    cordic_t                 v1p_reg;
    logic signed [VEC_W-1:0] v1p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1p_valid_reg <= 1'b0;
        else if (en)
            v1p_valid_reg <= n_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1p_reg      <= vec_prefix(lsin_n_reg, lcos_n_reg);
            v1p_side_reg <= sinb_n_reg;
        end
    end

    logic                    v1_valid;
    cordic_t                 v1_out;
    logic        [VEC_W-1:0] v1_side;

    e2g_cordic #(.VECTOR(1'b1), .SIDE_W(VEC_W)) u_vec_lon (
        .clk (clk), .rst_n (rst_n), .en (en),
        .valid_i (v1p_valid_reg), .d_i (v1p_reg), .side_i (v1p_side_reg),
        .valid_o (v1_valid), .d_o (v1_out), .side_o (v1_side)
    );

    // cos b from the cordic magnitude
    logic signed [VEC_W-1:0]   mag;
    logic signed [2*VEC_W-1:0] mag_prod;

    assign mag      = v1_out.zero ? '0 : v1_out.x;
    assign mag_prod = mag * GAIN_INV;

    logic                    c_valid_reg;
    logic signed [VEC_W-1:0] cb_c_reg;
    logic signed [VEC_W-1:0] sinb_c_reg;
    logic [TURN_W-1:0]       phi_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= v1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_c_reg   <= VEC_W'(mag_prod >>> VEC_FRAC);
            sinb_c_reg <= signed'(v1_side);
            phi_c_reg  <= vec_angle(v1_out);
        end
    end

    // latitude vectoring, longitude angle rides along
    logic              v2p_valid_reg;
    cordic_t           v2p_reg;
    logic [TURN_W-1:0] v2p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2p_valid_reg <= 1'b0;
        else if (en)
            v2p_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v2p_reg      <= vec_prefix(sinb_c_reg, cb_c_reg);
            v2p_side_reg <= phi_c_reg;
        end
    end

    logic              v2_valid;
    cordic_t           v2_out;
    logic [TURN_W-1:0] v2_side;

    e2g_cordic #(.VECTOR(1'b1), .SIDE_W(TURN_W)) u_vec_lat (
        .clk (clk), .rst_n (rst_n), .en (en),
        .valid_i (v2p_valid_reg), .d_i (v2p_reg), .side_i (v2p_side_reg),
        .valid_o (v2_valid), .d_o (v2_out), .side_o (v2_side)
    );

    // output register
    logic [TURN_W-1:0]       bang;
    logic signed [ACC_W-1:0] bs;
    logic signed [ACC_W-1:0] bs_clamped;
    logic [TURN_W-1:0]       lon;
    logic [ANGLE_BITS-1:0]   lon_reg;
    logic [ANGLE_BITS-1:0]   lat_reg;

    always_comb
    begin
        bang = vec_angle(v2_out);
        bs   = ACC_W'(signed'(bang));
        if (bs > QUARTER)
            bs_clamped = QUARTER;
        else if (bs < -QUARTER)
            bs_clamped = -QUARTER;
        else
            bs_clamped = bs;
        lon = node_lon_reg - v2_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lon_reg <= round_out(lon);
            lat_reg <= round_out(bs_clamped[TURN_W-1:0]);
        end
    end

    assign gal_out.valid              = out_valid_reg;
    assign gal_out.galactic_longitude = lon_reg;
    assign gal_out.galactic_latitude  = signed'(lat_reg);

`ifndef NO_ASSERTIONS
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        gal_out.valid |-> (gal_out.galactic_latitude <= LAT_MAX) &&
                          (gal_out.galactic_latitude >= -LAT_MAX))
        else $error("latitude beyond a quarter turn");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        gal_out.valid && !gal_out.ready |-> !sky_in.ready)
        else $error("input taken while output word stalled");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        gal_out.valid && !gal_out.ready |=> $stable(v2_valid) && $stable(c_valid_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== hw/rtl/e2g_cordic_stage.sv =====
module e2g_cordic_stage import e2g_pkg::*; #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_i,
    input  cordic_t           d_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output cordic_t           d_o,
    output logic [SIDE_W-1:0] side_o
);

    localparam logic signed [ACC_W-1:0] ATAN = ACC_W'(atan_entry(STEP));

    logic              valid_reg;
    cordic_t           d_reg;
    cordic_t           d_next;
    logic [SIDE_W-1:0] side_reg;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic              up;

    always_comb
    begin
        dx = d_i.y >>> STEP;
        dy = d_i.x >>> STEP;
        // vectoring drives y to zero, rotation drives z to zero
        up = VECTOR ? d_i.y[VEC_W-1] : ~d_i.z[ACC_W-1];
        d_next = d_i;
        if (up)
        begin
            d_next.x = d_i.x - dx;
            d_next.y = d_i.y + dy;
            d_next.z = d_i.z - ATAN;
        end
        else
        begin
            d_next.x = d_i.x + dx;
            d_next.y = d_i.y - dy;
            d_next.z = d_i.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign d_o     = d_reg;
    assign side_o  = side_reg;

endmodule

// ===== hw/rtl/e2g_cordic.sv =====
module e2g_cordic import e2g_pkg::*; #(
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_i,
    input  cordic_t           d_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output cordic_t           d_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              valid_s [CORDIC_STEPS+1];
    cordic_t           d_s     [CORDIC_STEPS+1];
    logic [SIDE_W-1:0] side_s  [CORDIC_STEPS+1];

    assign valid_s[0] = valid_i;
    assign d_s[0]     = d_i;
    assign side_s[0]  = side_i;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_step
        e2g_cordic_stage #(
            .STEP   (g),
            .VECTOR (VECTOR),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid_i (valid_s[g]),
            .d_i     (d_s[g]),
            .side_i  (side_s[g]),
            .valid_o (valid_s[g+1]),
            .d_o     (d_s[g+1]),
            .side_o  (side_s[g+1])
        );
    end

    assign valid_o = valid_s[CORDIC_STEPS];
    assign d_o     = d_s[CORDIC_STEPS];
    assign side_o  = side_s[CORDIC_STEPS];

endmodule
